// ===== src/lsds_pkg.sv =====
// Shared types, constants and helper functions for the LED slot dither scheduler.
// Used by the controller, the datapath and the top level; depends on nothing else.
package lsds_pkg;

    localparam int LSDS_NUM_ENTRIES = 13;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 8;

    localparam logic [CFG_IDX_W-1:0] REG_BEAT_TICKS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DIR = 2'd1;

    localparam logic [7:0] BEAT_TICKS_RST  = 8'd64;
    localparam logic [7:0] DEFAULT_DIR_RST = 8'd255;
    localparam logic [7:0] TICKS_LEFT_RST  = 8'd64;

    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_CALC = 1'b1
    } lsds_state_t;

    typedef struct packed {
        logic load;
        logic slot;
        logic commit;
    } lsds_cmd_t;

    typedef struct packed {
        logic out_full;
    } lsds_status_t;

    // Dither phase sequence 0, 3, 1, 2.
    function automatic logic [1:0] next_dither(input logic [1:0] d);
        logic [1:0] n;
        begin
            n = d ^ 2'b10;
            if (n[1])
            begin
                n = n ^ 2'b01;
            end
            return n;
        end
    endfunction

endpackage

// ===== src/lsds_ctrl.sv =====
// Controller state machine of the LED slot dither scheduler.
// Depends on lsds_pkg for the state type and the command and status structs.
module lsds_ctrl
    import lsds_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         mode,
    output logic         in_stall,
    output lsds_cmd_t    cmd,
    input  lsds_status_t status
);

    lsds_state_t state_reg;
    lsds_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && mode)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (!status.out_full)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall   = 1'b1;
        cmd.load   = 1'b0;
        cmd.slot   = 1'b0;
        cmd.commit = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid && !mode;
                cmd.slot = in_valid && mode;
            end
            ST_CALC:
            begin
                cmd.commit = !status.out_full;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== src/lsds_datapath.sv =====
// Datapath of the LED slot dither scheduler: entry table, beat state and output word.
// Depends on lsds_pkg; driven by the command struct from lsds_ctrl.
module lsds_datapath
    import lsds_pkg::*;
#(
    parameter int NUM_ENTRIES = LSDS_NUM_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  lsds_cmd_t             cmd,
    output lsds_status_t          status,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [3:0]            entry_index,
    input  logic [7:0]            entry_dir,
    input  logic [7:0]            entry_port,
    input  logic [7:0]            entry_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            led_port,
    output logic [7:0]            led_dir,
    output logic [7:0]            compare_value,
    output logic                  deep_sleep,
    output logic                  end_of_beat,
    output logic [3:0]            slot_index
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    logic [23:0]      table_mem [NUM_ENTRIES];
    logic [23:0]      rd_data_reg;
    logic [IDX_W-1:0] pointer_reg;
    logic [IDX_W-1:0] pointer_next;
    logic [7:0]       ticks_left_reg;
    logic [7:0]       ticks_left_next;
    logic [1:0]       dither_reg;
    logic [1:0]       dither_next;
    logic [7:0]       beat_ticks_reg;
    logic [7:0]       default_dir_reg;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       port_reg;
    logic [7:0]       dir_reg;
    logic [7:0]       cmp_reg;
    logic             eob_reg;
    logic [3:0]       index_reg;

    logic [7:0] rd_dir;
    logic [7:0] rd_port;
    logic [7:0] rd_value;
    logic [7:0] sum;
    logic [5:0] t_shift;
    logic [7:0] t_min;
    logic [7:0] t_slot;
    logic [7:0] dir_sel;
    logic [7:0] cmp;
    logic [7:0] remain;
    logic       eob;

    always_ff @(posedge clk)
    begin
        if (cmd.load && (32'(entry_index) < NUM_ENTRIES))
        begin
            table_mem[IDX_W'(entry_index)] <= {entry_dir, entry_port, entry_value};
        end
        if (cmd.slot)
        begin
            rd_data_reg <= table_mem[pointer_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_ticks_reg  <= BEAT_TICKS_RST;
            default_dir_reg <= DEFAULT_DIR_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BEAT_TICKS:  beat_ticks_reg  <= cfg_data;
                REG_DEFAULT_DIR: default_dir_reg <= cfg_data;
                default:         beat_ticks_reg  <= beat_ticks_reg;
            endcase
        end
    end

    assign rd_dir   = rd_data_reg[23:16];
    assign rd_port  = rd_data_reg[15:8];
    assign rd_value = rd_data_reg[7:0];

    always_comb
    begin
        sum     = rd_value + 8'(dither_reg) + ((rd_value < 8'd8) ? 8'(dither_reg) : 8'd0);
        t_shift = sum[7:2];
        if (t_shift < 6'd2)
        begin
            t_min   = 8'd2;
            dir_sel = default_dir_reg;
        end
        else
        begin
            t_min   = {2'b00, t_shift};
            dir_sel = rd_dir;
        end
        if ((t_min > ticks_left_reg) || (rd_value == 8'd0))
        begin
            t_slot = ticks_left_reg;
        end
        else
        begin
            t_slot = t_min;
        end
        cmp    = t_slot - 8'd1;
        remain = ticks_left_reg - t_slot;
        eob    = remain < 8'd2;
    end

    always_comb
    begin
        pointer_next    = pointer_reg;
        ticks_left_next = ticks_left_reg;
        dither_next     = dither_reg;
        if (cmd.commit)
        begin
            if (eob)
            begin
                pointer_next    = '0;
                ticks_left_next = remain + beat_ticks_reg;
                dither_next     = next_dither(dither_reg);
            end
            else
            begin
                ticks_left_next = remain;
                pointer_next    = (pointer_reg == LAST_IDX) ? LAST_IDX : pointer_reg + 1'b1;
            end
        end
        out_valid_next = cmd.commit || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pointer_reg    <= '0;
            ticks_left_reg <= TICKS_LEFT_RST;
            dither_reg     <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pointer_reg    <= pointer_next;
            ticks_left_reg <= ticks_left_next;
            dither_reg     <= dither_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            port_reg  <= rd_port;
            dir_reg   <= dir_sel;
            cmp_reg   <= cmp;
            eob_reg   <= eob;
            index_reg <= 4'(pointer_reg);
        end
    end

    assign status.out_full = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign led_port        = port_reg;
    assign led_dir         = dir_reg;
    assign compare_value   = cmp_reg;
    assign deep_sleep      = |cmp_reg[7:1];
    assign end_of_beat     = eob_reg;
    assign slot_index      = index_reg;

endmodule

// ===== src/led_slot_dither_scheduler.sv =====
// Top level of the LED slot dither scheduler.
// Instantiates lsds_ctrl and lsds_datapath; depends on lsds_pkg.
//
// A load word (mode 0) writes one table entry and is taken without a stall; a slot word
// (mode 1) reads the table entry at the slot pointer into a register in ST_IDLE, then works
// out the tick count and updates the beat state in ST_CALC, so the block takes no new word
// until the slot is done. The input is stalled in ST_CALC, and for longer while the previous
// result word is still held by a stalled output. Configuration writes are taken at any time
// and there is no clearing pass after reset.
module led_slot_dither_scheduler
    import lsds_pkg::*;
#(
    parameter int NUM_ENTRIES = LSDS_NUM_ENTRIES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  mode,
    input  logic [3:0]            entry_index,
    input  logic [7:0]            entry_dir,
    input  logic [7:0]            entry_port,
    input  logic [7:0]            entry_value,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [7:0]            led_port,
    output logic [7:0]            led_dir,
    output logic [7:0]            compare_value,
    output logic                  deep_sleep,
    output logic                  end_of_beat,
    output logic [3:0]            slot_index
);

    lsds_cmd_t    cmd;
    lsds_status_t status;

    lsds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (mode),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status)
    );

    lsds_datapath #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .entry_index   (entry_index),
        .entry_dir     (entry_dir),
        .entry_port    (entry_port),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_port      (led_port),
        .led_dir       (led_dir),
        .compare_value (compare_value),
        .deep_sleep    (deep_sleep),
        .end_of_beat   (end_of_beat),
        .slot_index    (slot_index)
    );

endmodule

// ===== tb/sv/tb_led_slot_dither_scheduler.sv =====
`timescale 1ns / 100ps
// Testbench for the LED slot dither scheduler: directed and random load and slot words,
// each result word checked against a behavioural model of the table, beat timer and dither.
// Depends on lsds_pkg and led_slot_dither_scheduler.
module tb_led_slot_dither_scheduler;
    import lsds_pkg::*;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_SLOT = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int MAX_REPORTS = 10;
    localparam logic [8*LSDS_NUM_ENTRIES-1:0] SEED_VALUES = {
        8'd3, 8'd64, 8'd9, 8'd100, 8'd4, 8'd30, 8'd0,
        8'd12, 8'd200, 8'd8, 8'd7, 8'd1, 8'd255
    };

    typedef struct {
        logic [7:0] led_port;
        logic [7:0] led_dir;
        logic [7:0] compare_value;
        logic       deep_sleep;
        logic       end_of_beat;
        logic [3:0] slot_index;
    } slot_word_t;

    class slot_ledger;
        logic [7:0]  tbl_dir [LSDS_NUM_ENTRIES];
        logic [7:0]  tbl_port [LSDS_NUM_ENTRIES];
        logic [7:0]  tbl_value [LSDS_NUM_ENTRIES];
        int unsigned ptr = 0;
        logic [7:0]  ticks_left = TICKS_LEFT_RST;
        logic [1:0]  dither = 2'd0;
        logic [7:0]  beat_ticks = BEAT_TICKS_RST;
        logic [7:0]  default_dir = DEFAULT_DIR_RST;
        slot_word_t  due_slots [$];
        int          mismatches = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_BEAT_TICKS)
                beat_ticks = data;
            else if (idx == REG_DEFAULT_DIR)
                default_dir = data;
        endfunction

        function int pending();
            return due_slots.size();
        endfunction

        function int failures();
            return mismatches + due_slots.size();
        endfunction

        function logic [1:0] next_phase(logic [1:0] d);
            case (d)
                2'd0: return 2'd3;
                2'd3: return 2'd1;
                2'd1: return 2'd2;
                default: return 2'd0;
            endcase
        endfunction

        function void take_word(logic m, logic [3:0] idx, logic [7:0] d, logic [7:0] p,
                                logic [7:0] v);
            slot_word_t w;
            logic [7:0] t;
            logic [7:0] val;
            if (m == MODE_LOAD)
            begin
                if (idx < LSDS_NUM_ENTRIES)
                begin
                    tbl_dir[idx] = d;
                    tbl_port[idx] = p;
                    tbl_value[idx] = v;
                end
                return;
            end
            val = tbl_value[ptr];
            w.led_port = tbl_port[ptr];
            w.led_dir = tbl_dir[ptr];
            w.slot_index = ptr[3:0];
            t = val;
            if (val < 8'd8)
                t = t + dither;
            t = t + dither;
            t = t >> 2;
            if (t < 8'd2)
            begin
                w.led_dir = default_dir;
                t = 8'd2;
            end
            if (t > ticks_left || val == 8'd0)
                t = ticks_left;
            w.compare_value = t - 8'd1;
            w.deep_sleep = |w.compare_value[7:1];
            ticks_left = ticks_left - t;
            w.end_of_beat = ticks_left < 8'd2;
            if (w.end_of_beat)
            begin
                ptr = 0;
                ticks_left = ticks_left + beat_ticks;
                dither = next_phase(dither);
            end
            else if (ptr < LSDS_NUM_ENTRIES - 1)
            begin
                ptr++;
            end
            due_slots.push_back(w);
        endfunction

        function void check_slot(slot_word_t got);
            slot_word_t want;
            if (due_slots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected slot word port %h dir %h cmp %h index %0d",
                             $time, got.led_port, got.led_dir, got.compare_value,
                             got.slot_index);
                return;
            end
            want = due_slots.pop_front();
            if (got.led_port !== want.led_port || got.led_dir !== want.led_dir
                || got.compare_value !== want.compare_value
                || got.deep_sleep !== want.deep_sleep
                || got.end_of_beat !== want.end_of_beat
                || got.slot_index !== want.slot_index)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: slot got %h %h %h %b %b %0d, expected %h %h %h %b %b %0d",
                             $time, got.led_port, got.led_dir, got.compare_value,
                             got.deep_sleep, got.end_of_beat, got.slot_index,
                             want.led_port, want.led_dir, want.compare_value,
                             want.deep_sleep, want.end_of_beat, want.slot_index);
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic                  mode;
    logic [3:0]            entry_index;
    logic [7:0]            entry_dir;
    logic [7:0]            entry_port;
    logic [7:0]            entry_value;
    logic                  out_valid;
    logic                  out_stall;
    logic [7:0]            led_port;
    logic [7:0]            led_dir;
    logic [7:0]            compare_value;
    logic                  deep_sleep;
    logic                  end_of_beat;
    logic [3:0]            slot_index;

    slot_ledger ledger = new;
    bit         tx_idling = 1'b0;
    bit         rx_idling = 1'b0;
    int         rx_hold_cycles = 0;

    led_slot_dither_scheduler DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .entry_index   (entry_index),
        .entry_dir     (entry_dir),
        .entry_port    (entry_port),
        .entry_value   (entry_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .led_port      (led_port),
        .led_dir       (led_dir),
        .compare_value (compare_value),
        .deep_sleep    (deep_sleep),
        .end_of_beat   (end_of_beat),
        .slot_index    (slot_index)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        slot_word_t seen;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.led_port = led_port;
            seen.led_dir = led_dir;
            seen.compare_value = compare_value;
            seen.deep_sleep = deep_sleep;
            seen.end_of_beat = end_of_beat;
            seen.slot_index = slot_index;
            ledger.check_slot(seen);
        end
        if (rst_n && in_valid && !in_stall)
            ledger.take_word(mode, entry_index, entry_dir, entry_port, entry_value);
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_cycles != 0)
            begin
                out_stall <= 1'b1;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
                out_stall <= 1'b0;
            end
            else if (rx_idling && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(logic m, logic [3:0] idx, logic [7:0] d, logic [7:0] p,
                             logic [7:0] v);
        in_valid <= 1'b1;
        mode <= m;
        entry_index <= idx;
        entry_dir <= d;
        entry_port <= p;
        entry_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        ledger.set_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (ledger.pending() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic logic [7:0] pick_value(bit allow_zero);
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return allow_zero ? 8'd0 : 8'd255;
        else if (sel <= 4)
            return 8'($urandom_range(1, 15));
        else if (sel <= 7)
            return 8'($urandom_range(16, 63));
        return 8'($urandom_range(64, 255));
    endfunction

    task automatic send_many(int words, bit allow_zero);
        logic m;
        for (int i = 0; i < words; i++)
        begin
            m = ($urandom_range(0, 99) < 65) ? MODE_SLOT : MODE_LOAD;
            send_word(m, 4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom),
                      pick_value(allow_zero));
            if (tx_idling && $urandom_range(0, 5) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        mode = MODE_LOAD;
        entry_index = '0;
        entry_dir = '0;
        entry_port = '0;
        entry_value = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < LSDS_NUM_ENTRIES; i++)
            send_word(MODE_LOAD, 4'(i), i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF,
                      SEED_VALUES[8*i +: 8]);
        send_word(MODE_LOAD, 4'd13, 8'hFF, 8'hFF, 8'd0);
        send_word(MODE_LOAD, 4'd15, 8'h00, 8'h00, 8'd0);
        for (int i = 0; i < 8; i++)
            send_word(MODE_SLOT, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

        tx_idling = 1'b1;
        rx_idling = 1'b1;
        drain();
        write_reg(REG_BEAT_TICKS, 8'd255);
        write_reg(REG_DEFAULT_DIR, 8'h00);
        send_many(60, 1'b1);
        tx_idling = 1'b0;
        rx_hold_cycles = 80;
        send_many(60, 1'b1);
        tx_idling = 1'b1;
        drain();
        send_many(80, 1'b1);

        drain();
        write_reg(REG_BEAT_TICKS, 8'd0);
        write_reg(REG_DEFAULT_DIR, 8'hFF);
        send_many(150, 1'b1);

        drain();
        write_reg(REG_BEAT_TICKS, 8'd200);
        write_reg(REG_DEFAULT_DIR, 8'h5A);
        send_many(150, 1'b0);

        drain();
        write_reg(REG_BEAT_TICKS, 8'd1);
        write_reg(REG_DEFAULT_DIR, 8'($urandom));
        send_many(150, 1'b1);

        drain();
        write_reg(REG_UNUSED, 8'($urandom));
        write_reg(REG_BEAT_TICKS, 8'($urandom));
        write_reg(REG_DEFAULT_DIR, 8'($urandom));
        send_many(200, 1'b1);

        drain();
        tx_idling = 1'b0;
        rx_idling = 1'b0;
        write_reg(REG_BEAT_TICKS, BEAT_TICKS_RST);
        write_reg(REG_DEFAULT_DIR, DEFAULT_DIR_RST);
        send_many(200, 1'b1);
        drain();

        if (ledger.failures() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
